### rtl/core/pse_pkg.sv
// shared constants, types and helpers for the postfix stack evaluator
// no dependencies

package pse_pkg;

	localparam int StackDepth = 128;
	localparam int ValueWidth = 32;
	localparam int OutWidth   = 32;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChStar  = 8'h2A;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChPct   = 8'h25;
	localparam logic [7:0] ChCaret = 8'h5E;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4,
		OP_POW = 3'd5,
		OP_NONE = 3'd6
	} op_t;

	function automatic logic is_operand(input logic [7:0] c);
		is_operand = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic op_t decode_op(input logic [7:0] c);
		unique case (c)
			ChPlus:  decode_op = OP_ADD;
			ChMinus: decode_op = OP_SUB;
			ChStar:  decode_op = OP_MUL;
			ChSlash: decode_op = OP_DIV;
			ChPct:   decode_op = OP_REM;
			ChCaret: decode_op = OP_POW;
			default: decode_op = OP_NONE;
		endcase
	endfunction

endpackage

### rtl/core/pse_stream_if.sv
// valid/ready channel carrying a generic payload
// depends on nothing

interface pse_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/pse_ram.sv
// generic single port ram, registered read
// no dependencies

module pse_ram #(
	parameter int Width = 32,
	parameter int Depth = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/core/pse_alu.sv
// multi-cycle arithmetic unit: add, sub, mul, div/rem (restoring), power by squaring
// depends on pse_pkg

module pse_alu #(
	parameter int ValueWidth = pse_pkg::ValueWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  pse_pkg::op_t          op,
	input  logic [ValueWidth-1:0] a,
	input  logic [ValueWidth-1:0] b,
	output logic                  done,
	output logic [ValueWidth-1:0] result,
	output logic                  divz
);
	localparam int CntW = $clog2(ValueWidth + 1);
	localparam logic [CntW-1:0] LastStep = CntW'(ValueWidth - 1);

	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_DIV  = 4'b0010,
		A_POW  = 4'b0100,
		A_FIN  = 4'b1000
	} astate_t;

	astate_t state_q;
	logic [CntW-1:0] cnt_q;
	logic [ValueWidth-1:0] quo_q, rem_q, dvs_q, acc_q, sq_q, ex_q, res_q;
	logic neg_q, rem_mode_q, divz_q, mul_phase_q;
	logic [ValueWidth:0] trial;
	logic [ValueWidth-1:0] rem_sh;
	logic [ValueWidth-1:0] ma, mb;
	logic all_ones;

	assign ma = a[ValueWidth-1] ? (~a + 1'b1) : a;
	assign mb = b[ValueWidth-1] ? (~b + 1'b1) : b;
	assign all_ones = &a;
	assign rem_sh = {rem_q[ValueWidth-2:0], quo_q[ValueWidth-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			unique case (state_q)
				A_IDLE: if (start) begin
					if (op == pse_pkg::OP_DIV || op == pse_pkg::OP_REM)
						state_q <= (b == '0) ? A_FIN : A_DIV;
					else if (op == pse_pkg::OP_POW && !b[ValueWidth-1])
						state_q <= A_POW;
					else
						state_q <= A_FIN;
				end
				A_DIV: if (cnt_q == LastStep) state_q <= A_FIN;
				A_POW: if (cnt_q == LastStep && mul_phase_q) state_q <= A_FIN;
				A_FIN: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				cnt_q <= '0;
				mul_phase_q <= 1'b0;
				divz_q <= 1'b0;
				neg_q <= (op == pse_pkg::OP_REM) ? a[ValueWidth-1] :
					(a[ValueWidth-1] ^ b[ValueWidth-1]);
				rem_mode_q <= (op == pse_pkg::OP_REM);
				quo_q <= ma;
				rem_q <= '0;
				dvs_q <= mb;
				acc_q <= ValueWidth'(1);
				sq_q <= a;
				ex_q <= b;
				case (op)
					pse_pkg::OP_ADD: res_q <= a + b;
					pse_pkg::OP_SUB: res_q <= a - b;
					pse_pkg::OP_MUL: res_q <= a * b;
					pse_pkg::OP_DIV, pse_pkg::OP_REM: begin
						res_q <= '0;
						divz_q <= (b == '0);
					end
					pse_pkg::OP_POW: begin
						// negative exponent truncates toward zero
						if (b[ValueWidth-1]) begin
							if (a == '0) begin
								res_q <= '0;
								divz_q <= 1'b1;
							end else if (a == ValueWidth'(1)) begin
								res_q <= ValueWidth'(1);
							end else if (all_ones) begin
								res_q <= b[0] ? '1 : ValueWidth'(1);
							end else begin
								res_q <= '0;
							end
						end else begin
							res_q <= '0;
						end
					end
					default: res_q <= '0;
				endcase
			end
			A_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (!trial[ValueWidth]) begin
					rem_q <= trial[ValueWidth-1:0];
					quo_q <= {quo_q[ValueWidth-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[ValueWidth-2:0], 1'b0};
				end
				if (cnt_q == LastStep) begin
					if (rem_mode_q)
						res_q <= neg_q ? (~(trial[ValueWidth] ? rem_sh : trial[ValueWidth-1:0])
							+ 1'b1) : (trial[ValueWidth] ? rem_sh : trial[ValueWidth-1:0]);
					else
						res_q <= neg_q ? (~{quo_q[ValueWidth-2:0], ~trial[ValueWidth]} + 1'b1)
							: {quo_q[ValueWidth-2:0], ~trial[ValueWidth]};
				end
			end
			A_POW: begin
				// alternate: multiply accumulator, then square
				mul_phase_q <= ~mul_phase_q;
				if (!mul_phase_q) begin
					if (ex_q[0]) acc_q <= acc_q * sq_q;
				end else begin
					sq_q <= sq_q * sq_q;
					ex_q <= ex_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastStep) res_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign done = (state_q == A_FIN);
	assign result = res_q;
	assign divz = divz_q;
endmodule

### rtl/core/postfix_stack_evaluator.sv
// top level of the postfix stack evaluator: sequencer around the stack ram and alu
// depends on pse_pkg, pse_stream_if, pse_ram, pse_alu
//
// channel   dir  payload                         request when
// in_ch     in   symbol[7:0], last               valid && ready
// out_ch    out  value[31:0] signed, status[1:0] valid && ready
//
// an operand is pushed; any other symbol pops two entries, b and then a, and an operator
// runs in the alu and pushes its result: / and % by a nonzero divisor use the iterative
// divider and ^ with a non-negative exponent the square-and-multiply loop; a last item
// then reads the top entry out as the result
// reset clears the stack count, error status and handshake state; ram is not cleared
// one item is in work at a time; a finished result waits in the output register
// and no request is taken until that result has been accepted

module postfix_stack_evaluator #(
	parameter int StackDepth = pse_pkg::StackDepth,
	parameter int ValueWidth = pse_pkg::ValueWidth
) (
	input logic clk,
	input logic arst_n,
	pse_stream_if.sink   in_ch,
	pse_stream_if.source out_ch
);
	localparam int AddrW = $clog2(StackDepth);
	localparam int CntW  = $clog2(StackDepth + 1);
	localparam int OutW  = pse_pkg::OutWidth;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_POPB  = 7'b0000010,
		S_POPA  = 7'b0000100,
		S_CALC  = 7'b0001000,
		S_PUSH  = 7'b0010000,
		S_FINAL = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CntW-1:0] count_q;
	pse_pkg::status_t status_q;
	logic last_q;
	pse_pkg::op_t op_q;
	logic [ValueWidth-1:0] a_q, b_q, push_q;
	logic out_valid_q;
	logic [OutW-1:0] out_value_q;
	pse_pkg::status_t out_status_q;

	// ram port
	logic ram_we;
	logic [AddrW-1:0] ram_addr;
	logic [ValueWidth-1:0] ram_wdata, ram_rdata;
	logic rd_pend_q; // read issued in the previous cycle
	logic rd_hit_q;  // read was of a real entry (not underflow)

	logic alu_start, alu_done, alu_divz;
	logic [ValueWidth-1:0] alu_res;
	logic [ValueWidth-1:0] pop_val;

	pse_ram #(.Width(ValueWidth), .Depth(StackDepth)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	pse_alu #(.ValueWidth(ValueWidth)) u_alu (
		.clk(clk), .arst_n(arst_n), .start(alu_start), .op(op_q), .a(a_q), .b(b_q),
		.done(alu_done), .result(alu_res), .divz(alu_divz)
	);

	// popped value: ram data, or -1 on underflow
	assign pop_val = rd_hit_q ? ram_rdata : '1;

	// stack pointer: read top on pops, write at count on push
	always_comb begin
		ram_we = 1'b0;
		ram_wdata = push_q;
		ram_addr = AddrW'(count_q - 1'b1);
		if (state_q == S_PUSH) begin
			ram_addr = AddrW'(count_q);
			ram_we = (count_q < CntW'(StackDepth));
		end
	end

	assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
	assign alu_start = (state_q == S_CALC) && !rd_pend_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data.value = out_value_q;
	assign out_ch.data.status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			status_q <= pse_pkg::ST_OK;
			out_valid_q <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_hit_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			rd_pend_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					if (pse_pkg::is_operand(in_ch.data.symbol)) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_POPB;
					end
				end
				S_POPB, S_POPA: begin
					// issue read of top entry
					rd_pend_q <= 1'b1;
					rd_hit_q <= (count_q != '0);
					if (count_q != '0) count_q <= count_q - 1'b1;
					else if (status_q == pse_pkg::ST_OK) status_q <= pse_pkg::ST_UNDER;
					state_q <= (state_q == S_POPB) ? S_POPA : S_CALC;
				end
				S_CALC: begin
					if (!rd_pend_q && (op_q == pse_pkg::OP_NONE)) begin
						state_q <= last_q ? S_FINAL : S_IDLE;
					end else if (alu_done) begin
						if (alu_divz && status_q == pse_pkg::ST_OK) status_q <= pse_pkg::ST_DIVZ;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (count_q < CntW'(StackDepth)) count_q <= count_q + 1'b1;
					else if (status_q == pse_pkg::ST_OK) status_q <= pse_pkg::ST_OVER;
					state_q <= last_q ? S_FINAL : S_IDLE;
				end
				S_FINAL: begin
					rd_pend_q <= 1'b1;
					rd_hit_q <= (count_q != '0);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					out_valid_q <= 1'b1;
					count_q <= '0;
					status_q <= pse_pkg::ST_OK;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid && in_ch.ready) begin
			last_q <= in_ch.data.last;
			op_q <= pse_pkg::decode_op(in_ch.data.symbol);
			push_q <= ValueWidth'(in_ch.data.symbol) - ValueWidth'(pse_pkg::ChZero);
		end
		if (state_q == S_POPA) b_q <= pop_val;
		if (state_q == S_CALC && rd_pend_q) a_q <= pop_val;
		if (state_q == S_CALC && alu_done) push_q <= alu_res;
		if (state_q == S_EMIT) begin
			out_value_q <= OutW'(signed'(pop_val));
			// underflow on the final pop counts as the first error only if none yet
			out_status_q <= (!rd_hit_q && status_q == pse_pkg::ST_OK) ?
				pse_pkg::ST_UNDER : status_q;
		end
	end
endmodule

### rtl/core/pse_checker.sv
// port-level checker for the postfix stack evaluator, bound to the top level
// depends on the top level's ports

module pse_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_value,
	input logic [1:0] out_status
);
	// result held while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
		else $error("result changed while stalled");

	// no request taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	// a request is taken only with a gap before the next
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back to back input taken");

	// out valid rises only while input is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");
endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_value(out_ch.data.value), .out_status(out_ch.data.status)
);

### tb/postfix_stack_evaluator_test.sv
`timescale 1ns / 1ps
// self-checking bench for postfix_stack_evaluator: random and directed postfix expressions
// depends on pse_pkg, pse_stream_if and the evaluator rtl

module postfix_stack_evaluator_test;
	import pse_pkg::*;

	// payload layouts as listed at the head of the top level
	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} sym_req_t;

	typedef struct packed {
		logic signed [31:0] value;
		status_t            status;
	} eval_res_t;

	// one pending request plus the driver hints that go with it
	typedef struct {
		sym_req_t req;
		bit       drain_first;
	} pending_sym_t;

	localparam int HalfPeriod = 4;
	localparam int IdleLimit  = 3000;
	localparam int TailCycles = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pse_stream_if #(.payload_t(sym_req_t))  in_ch ();
	pse_stream_if #(.payload_t(eval_res_t)) out_ch ();

	postfix_stack_evaluator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #(HalfPeriod) clk = ~clk;

	// stimulus and scoreboard storage
	pending_sym_t symbols_q[$];
	eval_res_t    results_due[$];

	// shadow of the evaluator state
	logic [31:0] shadow_stack[StackDepth];
	int unsigned shadow_count;
	status_t     shadow_err;

	int error_cnt;
	int checked_cnt;
	int status_seen[4];
	int sym_sent_cnt;

	// handshake bookkeeping; the took flags are set at the rising edge and read at the falling edge
	bit in_took;
	bit out_took;
	int in_gap;
	int out_gap;
	bit burst_mode;
	int idle_cycles;

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
		error_cnt++;
	endtask

	// ---------------------------------------------------------------
	// shadow model of the evaluator
	// ---------------------------------------------------------------

	function automatic void note_err(input status_t code);
		if (shadow_err == ST_OK)
			shadow_err = code;
	endfunction

	function automatic void push_val(input logic [31:0] v);
		if (shadow_count >= StackDepth) begin
			note_err(ST_OVER);
		end else begin
			shadow_stack[shadow_count] = v;
			shadow_count++;
		end
	endfunction

	// empty stack pops read as all ones and flag underflow
	function automatic logic [31:0] pop_val();
		if (shadow_count == 0) begin
			note_err(ST_UNDER);
			return '1;
		end
		shadow_count--;
		return shadow_stack[shadow_count];
	endfunction

	// truncating divide; remainder follows the sign of the dividend
	function automatic logic [31:0] div_val(input logic [31:0] a, input logic [31:0] b,
			input bit want_rem);
		logic [31:0] ua, ub, r;
		if (b == 0) begin
			note_err(ST_DIVZ);
			return 0;
		end
		ua = a[31] ? -a : a;
		ub = b[31] ? -b : b;
		if (want_rem) begin
			r = ua % ub;
			return a[31] ? -r : r;
		end
		r = ua / ub;
		return (a[31] != b[31]) ? -r : r;
	endfunction

	// square and multiply; negative exponents truncate toward zero
	function automatic logic [31:0] pow_val(input logic [31:0] base, input logic [31:0] ex);
		logic [31:0] acc, sq;
		acc = 1;
		sq = base;
		if (ex[31]) begin
			if (base == 0) begin
				note_err(ST_DIVZ);
				return 0;
			end
			if (base == 1)
				return 1;
			if (base == '1)
				return ex[0] ? '1 : 32'd1;
			return 0;
		end
		for (int i = 0; i < 32; i++) begin
			if (ex[i])
				acc = acc * sq;
			sq = sq * sq;
		end
		return acc;
	endfunction

	function automatic bit operand_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
	endfunction

	function automatic op_t op_of(input logic [7:0] c);
		case (c)
			ChPlus:  return OP_ADD;
			ChMinus: return OP_SUB;
			ChStar:  return OP_MUL;
			ChSlash: return OP_DIV;
			ChPct:   return OP_REM;
			ChCaret: return OP_POW;
			default: return OP_NONE;
		endcase
	endfunction

	// apply one accepted request and, on a last one, queue the result it will produce
	function automatic void apply_symbol(input sym_req_t r);
		logic [31:0] a, b, v;
		eval_res_t res;
		if (operand_char(r.symbol)) begin
			push_val({24'd0, r.symbol} - {24'd0, ChZero});
		end else begin
			b = pop_val();
			a = pop_val();
			case (op_of(r.symbol))
				OP_ADD: push_val(a + b);
				OP_SUB: push_val(a - b);
				OP_MUL: push_val(a * b);
				OP_DIV: push_val(div_val(a, b, 1'b0));
				OP_REM: push_val(div_val(a, b, 1'b1));
				OP_POW: push_val(pow_val(a, b));
				default: ;
			endcase
		end
		if (r.last) begin
			v = pop_val();
			res.value = v;
			res.status = shadow_err;
			results_due.push_back(res);
			shadow_count = 0;
			shadow_err = ST_OK;
		end
	endfunction

	// ---------------------------------------------------------------
	// stimulus builders
	// ---------------------------------------------------------------

	task automatic add_sym(input logic [7:0] c, input bit is_last, input bit drain);
		pending_sym_t p;
		p.req.symbol = c;
		p.req.last = is_last;
		p.drain_first = drain;
		symbols_q.push_back(p);
	endtask

	// whole expression as a string, last flag on its final character
	task automatic add_expr(input string s);
		for (int i = 0; i < s.len(); i++)
			add_sym(s[i], i == s.len() - 1, 1'b0);
	endtask

	function automatic logic [7:0] rand_operand();
		case ($urandom_range(0, 2))
			0: return 8'("0") + 8'($urandom_range(0, 9));
			1: return 8'("a") + 8'($urandom_range(0, 25));
			default: return 8'("A") + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] rand_operator();
		logic [7:0] ops[6];
		ops = '{ChPlus, ChMinus, ChStar, ChSlash, ChPct, ChCaret};
		return ops[$urandom_range(0, 5)];
	endfunction

	// well-formed postfix of random length, so most expressions end clean
	task automatic add_random_expr();
		int depth, target, n;
		logic [7:0] c;
		depth = 0;
		n = 0;
		target = $urandom_range(1, 14);
		forever begin
			if (depth < 2 || (n < target && $urandom_range(0, 2) == 0)) begin
				c = rand_operand();
				depth++;
			end else begin
				c = rand_operator();
				depth--;
			end
			n++;
			if (n >= target && depth == 1) begin
				add_sym(c, 1'b1, 1'b0);
				break;
			end
			add_sym(c, 1'b0, 1'b0);
		end
	endtask

	// raw bytes: separators, stray operators, any code at all
	task automatic add_noise_expr();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			add_sym($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : rand_operand(),
				i == n - 1, 1'b0);
	endtask

	task automatic add_overflow_expr();
		for (int i = 0; i < StackDepth + 2; i++)
			add_sym(rand_operand(), 1'b0, 1'b0);
		add_sym(rand_operator(), 1'b1, 1'b0);
	endtask

	initial begin
		int pick;
		error_cnt = 0;

		// directed part: each operator, signs, errors, extreme codes
		add_expr("23+");
		add_expr("9z-");
		add_expr("zZ*");
		add_expr("07-2/");
		add_expr("07-2%");
		add_expr("29^");
		add_expr("201-^");
		add_expr("101-^");
		add_expr("01-03-^");
		add_expr("001-^");
		add_expr("00^");
		add_expr("50/");
		add_expr("50%");
		add_expr("+");
		add_expr("!");
		add_expr("+50/");
		// most negative value over -1 wraps, remainder 0
		add_expr("2O^01-/");
		add_expr("2O^01-%");
		add_sym(8'h00, 1'b0, 1'b0);
		add_sym(8'hFF, 1'b1, 1'b0);
		add_overflow_expr();

		// random part; one request waits for the block to drain first
		while (symbols_q.size() < 1250) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				add_random_expr();
			else if (pick < 97)
				add_noise_expr();
			else
				add_overflow_expr();
			if (symbols_q.size() > 600 && symbols_q.size() < 700)
				symbols_q[symbols_q.size() - 1].drain_first = 1'b0;
		end
		symbols_q[symbols_q.size() / 2].drain_first = 1'b1;
	end

	// ---------------------------------------------------------------
	// reset and driving
	// ---------------------------------------------------------------

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// acceptance of requests feeds the shadow model
	always @(posedge clk) begin
		in_took <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			apply_symbol(in_ch.data);
			sym_sent_cnt++;
		end
	end

	// sender: holds a request until taken, then waits its drawn gap
	always @(negedge clk) begin
		if (arst_n && !(in_ch.valid && !in_took)) begin
			if ($urandom_range(0, 49) == 0)
				burst_mode = !burst_mode;
			if (in_gap > 0) begin
				in_ch.valid <= 1'b0;
				in_gap--;
			end else if (symbols_q.size() > 0 &&
					(!symbols_q[0].drain_first || results_due.size() == 0)) begin
				in_ch.data <= symbols_q[0].req;
				in_ch.valid <= 1'b1;
				void'(symbols_q.pop_front());
				in_gap = burst_mode ? 0 : $urandom_range(0, 12);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver drops ready for a drawn gap after each result
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took)
				out_gap = burst_mode ? 0 : $urandom_range(0, 12);
			if (out_gap > 0) begin
				out_ch.ready <= 1'b0;
				out_gap--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// result checking and watchdog
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		eval_res_t exp_res;
		out_took <= arst_n && out_ch.valid && out_ch.ready;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (results_due.size() == 0) begin
				report("unexpected result", 0, out_ch.data.value);
			end else begin
				exp_res = results_due.pop_front();
				checked_cnt++;
				status_seen[exp_res.status]++;
				if (out_ch.data.value !== exp_res.value)
					report("value", exp_res.value, out_ch.data.value);
				if (out_ch.data.status !== exp_res.status)
					report("status", 32'(exp_res.status), 32'(out_ch.data.status));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("watchdog: no handshake for %0d cycles", IdleLimit);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// end of run: all requests taken, all results in, then a quiet tail
	initial begin
		wait (arst_n);
		wait (symbols_q.size() == 0);
		@(posedge clk);
		while (in_ch.valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		$display("covered %0d symbols, %0d expressions checked", sym_sent_cnt, checked_cnt);
		$display("status mix: ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (error_cnt == 0 && results_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
